// ===== src/bcil_pkg.sv =====
// ----------------------------------------------------------------------------
// bcil_pkg
// Shared widths, register indexes, reset values and control structs for the
// battery current iq limiter.
// ----------------------------------------------------------------------------
package bcil_pkg;

  localparam int LIMIT_W    = 16;
  localparam int PHASE_W    = 15;
  localparam int CAL_W      = 16;
  localparam int IBAT_W     = 17;
  localparam int VOLT_W     = 16;
  localparam int REQ_W      = 16;
  localparam int SCALE_SH   = 11;
  localparam int NUM_W      = LIMIT_W + SCALE_SH;
  localparam int DEN_W      = CAL_W + VOLT_W;
  localparam int CNT_W      = $clog2(NUM_W);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // release threshold: (limit * 9) / 10 via reciprocal multiply
  localparam int              X9_W        = LIMIT_W + 4;
  localparam logic [X9_W-1:0] HYST_RECIP  = 20'hCCCCD;
  localparam int              HYST_SH     = 23;

  localparam logic [CFG_IDX_W-1:0] REG_BATTERY_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_CAL   = 2'd2;

  localparam logic [LIMIT_W-1:0] BATTERY_LIMIT_RST = 16'd15000;
  localparam logic [PHASE_W-1:0] PHASE_LIMIT_RST   = 15'd1024;
  localparam logic [CAL_W-1:0]   CURRENT_CAL_RST   = 16'd0;

  typedef struct packed {
    logic capture;
    logic latch_upd;
    logic div_init;
    logic div_step;
    logic out_load;
  } bcil_cmd_t;

  typedef struct packed {
    logic out_free;
  } bcil_stat_t;

endpackage

// ===== src/bcil_ctrl.sv =====
// ----------------------------------------------------------------------------
// bcil_ctrl
// Sequencer: request capture, latch update, divider iterations, result load.
// ----------------------------------------------------------------------------
module bcil_ctrl
  import bcil_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  bcil_stat_t stat,
  output bcil_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LATCH = 4'b0010,
    S_DIV   = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_LATCH;
        end
      end
      S_LATCH: begin
        cmd.latch_upd = 1'b1;
        cmd.div_init  = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // wait until the output register can take the result
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// ===== src/bcil_dpath.sv =====
// ----------------------------------------------------------------------------
// bcil_dpath
// Config registers, hysteresis latch, restoring divider and output register.
// ----------------------------------------------------------------------------
module bcil_dpath
  import bcil_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic signed [IBAT_W-1:0] in_battery_current,
  input  logic [VOLT_W-1:0]        in_voltage_magnitude,
  input  logic signed [REQ_W-1:0]  in_torque_request,
  input  bcil_cmd_t                cmd,
  output bcil_stat_t               stat,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [PHASE_W-1:0]       out_iq_cap,
  output logic                     out_limit_active
);

  logic [LIMIT_W-1:0] lim_r;
  logic [PHASE_W-1:0] phase_r;
  logic [CAL_W-1:0]   cal_r;

  logic signed [IBAT_W-1:0] ibat_r;
  logic [VOLT_W-1:0]        volt_r;
  logic signed [REQ_W-1:0]  req_r;
  logic [DEN_W-1:0]         den_r;
  logic [LIMIT_W-1:0]       rel_r;
  logic                     latch_r;
  logic [DEN_W-1:0]         rem_r;
  logic [NUM_W-1:0]         quo_r;
  logic                     out_valid_r;
  logic [PHASE_W-1:0]       iq_r;
  logic                     act_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r   <= BATTERY_LIMIT_RST;
      phase_r <= PHASE_LIMIT_RST;
      cal_r   <= CURRENT_CAL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BATTERY_LIMIT: lim_r   <= cfg_data[LIMIT_W-1:0];
        REG_PHASE_LIMIT:   phase_r <= cfg_data[PHASE_W-1:0];
        REG_CURRENT_CAL:   cal_r   <= cfg_data[CAL_W-1:0];
        default: ;
      endcase
    end
  end

  // capture stage: denominator product and release threshold
  logic [X9_W-1:0]   lim_x9;
  logic [2*X9_W-1:0] rel_prod;
  logic [DEN_W-1:0]  den_prod;

  assign lim_x9   = {4'b0000, lim_r} + {1'b0, lim_r, 3'b000};
  assign rel_prod = {{X9_W{1'b0}}, lim_x9} * {{X9_W{1'b0}}, HYST_RECIP};
  assign den_prod = {{VOLT_W{1'b0}}, cal_r} * {{CAL_W{1'b0}}, in_voltage_magnitude};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ibat_r <= in_battery_current;
      volt_r <= in_voltage_magnitude;
      req_r  <= in_torque_request;
      den_r  <= den_prod;
      rel_r  <= rel_prod[HYST_SH+LIMIT_W-1:HYST_SH];
    end
  end

  // hysteresis latch, compared in a common signed range
  logic signed [IBAT_W:0] ibat_x, max_x, rel_x;

  assign ibat_x = {ibat_r[IBAT_W-1], ibat_r};
  assign max_x  = $signed({2'b00, lim_r});
  assign rel_x  = $signed({2'b00, rel_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r <= 1'b0;
    end else if (cmd.latch_upd) begin
      if (ibat_x > max_x) begin
        latch_r <= 1'b1;
      end else if (ibat_x < rel_x) begin
        latch_r <= 1'b0;
      end
    end
  end

  // restoring divider, one quotient bit per step
  logic [DEN_W:0] trial, diff;
  logic           ge;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= '0;
      quo_r <= {lim_r, {SCALE_SH{1'b0}}};
    end else if (cmd.div_step) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  // final selection
  logic [PHASE_W-1:0] ceil_v, clamp_v, cap_v;
  logic               bypass;

  assign ceil_v  = (phase_r == '0) ? PHASE_W'(1) : phase_r;
  assign bypass  = !latch_r || (cal_r == '0) || (volt_r == '0);
  assign clamp_v = (quo_r > NUM_W'(ceil_v)) ? ceil_v : quo_r[PHASE_W-1:0];

  always_comb begin
    if (bypass) begin
      cap_v = ceil_v;
    end else if (!req_r[REQ_W-1] && (clamp_v > req_r[PHASE_W-1:0])) begin
      cap_v = req_r[PHASE_W-1:0];
    end else begin
      cap_v = clamp_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      iq_r  <= cap_v;
      act_r <= latch_r;
    end
  end

  assign stat.out_free    = !out_valid_r || !out_stall;
  assign out_valid        = out_valid_r;
  assign out_iq_cap       = iq_r;
  assign out_limit_active = act_r;

endmodule

// ===== src/battery_current_iq_limiter_unit.sv =====
// Sequence: a request is captured, the latch updates, the 27-step restoring
// divider runs (one quotient bit per cycle) and the result is loaded once the
// output register is free; a new request is taken only after that load.
// A waiting result does not block acceptance of the next request.
// Reset (rst_n low, synchronous): latch released, config registers at their
// defaults, no result pending.
// ----------------------------------------------------------------------------
// battery_current_iq_limiter_unit
// Hysteresis battery current latch producing a quadrature current cap.
// ----------------------------------------------------------------------------
module battery_current_iq_limiter_unit
  import bcil_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [IBAT_W-1:0] in_battery_current,
  input  logic [VOLT_W-1:0]        in_voltage_magnitude,
  input  logic signed [REQ_W-1:0]  in_torque_request,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [PHASE_W-1:0]       out_iq_cap,
  output logic                     out_limit_active,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  bcil_cmd_t  cmd;
  bcil_stat_t stat;

  bcil_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bcil_dpath u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_battery_current   (in_battery_current),
    .in_voltage_magnitude (in_voltage_magnitude),
    .in_torque_request    (in_torque_request),
    .cmd                  (cmd),
    .stat                 (stat),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_iq_cap           (out_iq_cap),
    .out_limit_active     (out_limit_active)
  );

endmodule

// ===== src/bcil_checker.sv =====
// ----------------------------------------------------------------------------
// bcil_checker
// Port-level checks on request sequencing and result delivery.
// ----------------------------------------------------------------------------
module bcil_checker
  import bcil_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [PHASE_W-1:0]       out_iq_cap,
  input logic                     out_limit_active
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_iq_cap)
                               && $stable(out_limit_active))
    else $error("stalled result changed");

  // no result pending straight after reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an accepted request keeps the input busy while it is worked on
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall ##1 in_stall)
    else $error("input not busy after accepting a request");

  // a new result appears together with the input becoming free
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall && $past(in_stall))
    else $error("result loaded while sequencer busy");

endmodule

bind battery_current_iq_limiter_unit bcil_checker u_bcil_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_iq_cap           (out_iq_cap),
  .out_limit_active     (out_limit_active)
);
